[design/jvsfr_pkg.sv]
package jvsfr_pkg;

  // Line framing bytes
  localparam logic [7:0] SYNC_BYTE = 8'hE0;
  localparam logic [7:0] MARK_BYTE = 8'hD0;

  // Configuration port geometry
  localparam int ADDR_W = 2;
  localparam int DATA_W = 32;

  // Register byte addresses
  localparam logic [ADDR_W-1:0] REG_HOST_ADDRESS = 2'd0;

  // Frame status codes, reported on the last byte
  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_OTHER  = 3'd1,
    ST_BADSUM = 3'd2,
    ST_SHORT  = 3'd3,
    ST_EMPTY  = 3'd4
  } status_t;

endpackage

[design/jvsfr_apb_regs.sv]
module jvsfr_apb_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [jvsfr_pkg::ADDR_W-1:0] paddr,
  input  logic [jvsfr_pkg::DATA_W-1:0] pwdata,
  output logic [jvsfr_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output logic [7:0]                  host_address
);
  import jvsfr_pkg::*;

  logic wr_en;
  logic reg_hit;

  // Decode the register address
  assign reg_hit   = (paddr == REG_HOST_ADDRESS);
  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite && pready;

  // Capture host address on a completed write transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      host_address <= 8'h00;
    end else if (wr_en && reg_hit) begin
      host_address <= pwdata[7:0];
    end
  end

  // Return register contents on read
  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata = {{(DATA_W-8){1'b0}}, host_address};
    end
  end

endmodule

[design/jvs_frame_receiver.sv]
// Output: a decoded byte appears at the output register in the cycle after its
//   line byte is accepted; sync, mark and out-of-frame bytes produce nothing.
// Throughput: one line byte per cycle, set by the single result register;
//   rx_ready falls only while a result is held and frame_ready is low.
// Reset (rst, synchronous): clears frame state, host_address to 0, empties
//   the output register.
module jvs_frame_receiver (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [jvsfr_pkg::ADDR_W-1:0] paddr,
  input  logic [jvsfr_pkg::DATA_W-1:0] pwdata,
  output logic [jvsfr_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        rx_valid,
  output logic                        rx_ready,
  input  logic [7:0]                  rx_byte,
  output logic                        frame_valid,
  input  logic                        frame_ready,
  output logic [7:0]                  frame_byte,
  output logic [8:0]                  position,
  output logic                        last,
  output logic [2:0]                  status
);
  import jvsfr_pkg::*;

  logic [7:0] host_address;

  jvsfr_apb_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .host_address (host_address)
  );

  // Frame state
  logic       in_frame, in_frame_next;
  logic       escape_pending, escape_pending_next;
  logic [8:0] byte_count, byte_count_next;
  logic [7:0] declared_length, declared_length_next;
  logic [7:0] running_sum, running_sum_next;
  logic       node_matches, node_matches_next;

  // Result of the current byte
  logic       rx_take;
  logic       emit;
  logic [7:0] dec_byte;
  logic [7:0] len_eff;
  logic       node_eff;
  logic       fin;
  status_t    stat_next;
  status_t    out_status;

  assign rx_ready = !frame_valid || frame_ready;
  assign rx_take  = rx_valid && rx_ready;

  // Decode one line byte
  always_comb begin
    in_frame_next        = in_frame;
    escape_pending_next  = escape_pending;
    byte_count_next      = byte_count;
    declared_length_next = declared_length;
    running_sum_next     = running_sum;
    node_matches_next    = node_matches;
    emit                 = 1'b0;
    dec_byte             = escape_pending ? rx_byte + 8'd1 : rx_byte;
    len_eff              = (byte_count == 9'd1) ? dec_byte : declared_length;
    node_eff             = (byte_count == 9'd0) ? (dec_byte == host_address) : node_matches;
    fin                  = (byte_count == ({1'b0, len_eff} + 9'd1));
    stat_next            = ST_OK;

    // Pick status in priority order
    if (len_eff == 8'd0) begin
      stat_next = ST_EMPTY;
    end else if (!node_eff) begin
      stat_next = ST_OTHER;
    end else if (running_sum != dec_byte) begin
      stat_next = ST_BADSUM;
    end else if (len_eff < 8'd2) begin
      stat_next = ST_SHORT;
    end

    if (rx_byte == SYNC_BYTE) begin
      in_frame_next        = 1'b1;
      escape_pending_next  = 1'b0;
      byte_count_next      = 9'd0;
      running_sum_next     = 8'd0;
      node_matches_next    = 1'b0;
      declared_length_next = 8'd0;
    end else if (!in_frame) begin
      // drop bytes between frames
    end else if (rx_byte == MARK_BYTE) begin
      escape_pending_next = 1'b1;
    end else begin
      emit                 = 1'b1;
      escape_pending_next  = 1'b0;
      declared_length_next = len_eff;
      node_matches_next    = node_eff;
      running_sum_next     = running_sum + dec_byte;
      byte_count_next      = byte_count + 9'd1;
      if (fin) begin
        in_frame_next = 1'b0;
      end
    end
  end

  // Advance frame state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame        <= 1'b0;
      escape_pending  <= 1'b0;
      byte_count      <= 9'd0;
      declared_length <= 8'd0;
      running_sum     <= 8'd0;
      node_matches    <= 1'b0;
    end else if (rx_take) begin
      in_frame        <= in_frame_next;
      escape_pending  <= escape_pending_next;
      byte_count      <= byte_count_next;
      declared_length <= declared_length_next;
      running_sum     <= running_sum_next;
      node_matches    <= node_matches_next;
    end
  end

  // Hold result valid until the downstream transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (rx_take) begin
      frame_valid <= emit;
    end else if (frame_ready) begin
      frame_valid <= 1'b0;
    end
  end

  // Load result payload
  always_ff @(posedge clk) begin
    if (rx_take && emit) begin
      frame_byte <= dec_byte;
      position   <= byte_count;
      last       <= fin;
      out_status <= fin ? stat_next : ST_OK;
    end
  end

  assign status = out_status;

`ifndef SYNTHESIS
  a_status_only_last: assert property (@(posedge clk) disable iff (rst)
    frame_valid && !last |-> out_status == ST_OK)
    else $error("status set on a byte that is not last");

  a_empty_on_length: assert property (@(posedge clk) disable iff (rst)
    frame_valid && last && out_status == ST_EMPTY |-> position == 9'd1)
    else $error("empty frame not ended on the length byte");

  a_node_not_last: assert property (@(posedge clk) disable iff (rst)
    frame_valid && position == 9'd0 |-> !last)
    else $error("frame ended on the node byte");

  a_sync_opens: assert property (@(posedge clk) disable iff (rst)
    rx_take && rx_byte == SYNC_BYTE |=> in_frame && byte_count == 9'd0 && !escape_pending)
    else $error("sync did not open a fresh frame");

  a_escape_in_frame: assert property (@(posedge clk) disable iff (rst)
    escape_pending |-> in_frame)
    else $error("escape pending outside a frame");
`endif

endmodule

[tb/jvs_frame_receiver_checker.sv]
module jvs_frame_receiver_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [jvsfr_pkg::ADDR_W-1:0] paddr,
  input  logic [jvsfr_pkg::DATA_W-1:0] pwdata,
  input  logic                         pready,
  input  logic                         rx_valid,
  input  logic                         rx_ready,
  input  logic [7:0]                   rx_byte,
  input  logic                         frame_valid,
  input  logic                         frame_ready,
  input  logic [7:0]                   frame_byte,
  input  logic [8:0]                   position,
  input  logic                         last,
  input  logic [2:0]                   status,
  output int                           errors,
  output int                           outstanding
);
  import jvsfr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic [8:0] pos;
    logic       fin;
    status_t    st;
  } decoded_byte_t;

  // Deframer state as the block should hold it
  logic [7:0] host_addr;
  logic       dec_in_frame;
  logic       dec_escape;
  logic [8:0] dec_count;
  logic [7:0] dec_length;
  logic [7:0] dec_sum;
  logic       dec_node_ok;

  decoded_byte_t expected_bytes[$];

  // Decode one line byte; return 1 when it yields a frame byte
  function automatic bit decode_line_byte(input logic [7:0] raw, output decoded_byte_t res);
    logic [7:0] value;
    logic [8:0] pos;
    res = '0;
    if (raw == SYNC_BYTE) begin
      dec_in_frame = 1'b1;
      dec_escape   = 1'b0;
      dec_count    = '0;
      dec_sum      = '0;
      dec_node_ok  = 1'b0;
      dec_length   = '0;
      return 1'b0;
    end
    if (!dec_in_frame) return 1'b0;
    if (raw == MARK_BYTE) begin
      dec_escape = 1'b1;
      return 1'b0;
    end
    value = raw;
    if (dec_escape) begin
      value      = raw + 8'd1;
      dec_escape = 1'b0;
    end
    pos = dec_count;
    if (pos == 9'd0) dec_node_ok = (value == host_addr);
    else if (pos == 9'd1) dec_length = value;
    res.data = value;
    res.pos  = pos;
    res.st   = ST_OK;
    // Close the frame once length plus two bytes have been decoded
    if (pos >= 9'd1 && int'(pos) + 1 == int'(dec_length) + 2) begin
      res.fin = 1'b1;
      if (dec_length == 8'd0) res.st = ST_EMPTY;
      else if (!dec_node_ok) res.st = ST_OTHER;
      else if (dec_sum != value) res.st = ST_BADSUM;
      else if (dec_length < 8'd2) res.st = ST_SHORT;
      else res.st = ST_OK;
      dec_in_frame = 1'b0;
    end
    dec_sum   = dec_sum + value;
    dec_count = pos + 9'd1;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    decoded_byte_t want;
    decoded_byte_t got;
    if (rst) begin
      host_addr    = '0;
      dec_in_frame = 1'b0;
      dec_escape   = 1'b0;
      dec_count    = '0;
      dec_length   = '0;
      dec_sum      = '0;
      dec_node_ok  = 1'b0;
      expected_bytes.delete();
      errors      <= 0;
      outstanding <= 0;
    end else begin
      // Track register writes
      if (psel && penable && pwrite && pready && paddr == REG_HOST_ADDRESS)
        host_addr = pwdata[7:0];

      // Compare the output transaction with the oldest expectation
      if (frame_valid && frame_ready) begin
        if (expected_bytes.size() == 0) begin
          if (errors < 10)
            $display("unexpected frame byte: byte %02h pos %0d last %0b status %0d",
                     frame_byte, position, last, status);
          errors <= errors + 1;
        end else begin
          want = expected_bytes.pop_front();
          if (frame_byte !== want.data || position !== want.pos || last !== want.fin ||
              status !== want.st) begin
            if (errors < 10)
              $display("mismatch: want %02h/%0d/%0b/%0d got %02h/%0d/%0b/%0d",
                       want.data, want.pos, want.fin, want.st,
                       frame_byte, position, last, status);
            errors <= errors + 1;
          end
        end
      end

      // Predict from the accepted line transaction
      if (rx_valid && rx_ready) begin
        if (decode_line_byte(rx_byte, got)) expected_bytes.push_back(got);
      end
      outstanding <= expected_bytes.size();
    end
  end

endmodule

[tb/jvs_frame_receiver_test.sv]
module jvs_frame_receiver_test;
  import jvsfr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_ITEMS = 270;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              rx_valid;
  logic              rx_ready;
  logic [7:0]        rx_byte;
  logic              frame_valid;
  logic              frame_ready;
  logic [7:0]        frame_byte;
  logic [8:0]        position;
  logic              last;
  logic [2:0]        status;

  int          errors;
  int          outstanding;
  int          rx_taken;
  int          cycle_count = 0;
  logic [7:0]  host_now;
  bit          rx_steady;

  jvs_frame_receiver u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .rx_valid(rx_valid), .rx_ready(rx_ready), .rx_byte(rx_byte),
    .frame_valid(frame_valid), .frame_ready(frame_ready), .frame_byte(frame_byte),
    .position(position), .last(last), .status(status)
  );

  jvs_frame_receiver_checker u_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready),
    .rx_valid(rx_valid), .rx_ready(rx_ready), .rx_byte(rx_byte),
    .frame_valid(frame_valid), .frame_ready(frame_ready), .frame_byte(frame_byte),
    .position(position), .last(last), .status(status),
    .errors(errors), .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Count accepted line transactions and guard against a hang
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst) rx_taken <= 0;
    else if (rx_valid && rx_ready) rx_taken <= rx_taken + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("jvs_frame_receiver_test: done, errors");
      $finish;
    end
  end

  // Stall the frame consumer: mostly short stalls, some long, some free-running stretches
  initial begin
    int pick;
    int hold;
    frame_ready = 1'b0;
    forever begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        frame_ready <= 1'b1;
        hold = $urandom_range(1, 20);
      end else if (pick < 55) begin
        frame_ready <= 1'b1;
        hold = $urandom_range(50, 150);
      end else if (pick < 85) begin
        frame_ready <= 1'b0;
        hold = $urandom_range(1, 3);
      end else if (pick < 96) begin
        frame_ready <= 1'b0;
        hold = $urandom_range(4, 12);
      end else begin
        frame_ready <= 1'b0;
        hold = $urandom_range(20, 80);
      end
      repeat (hold) @(negedge clk);
    end
  end

  function automatic int gap_cycles();
    int pick;
    pick = $urandom_range(0, 99);
    if (rx_steady || pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return 8'd0;
    if (pick < 10) return 8'd1;
    if (pick < 85) return 8'($urandom_range(2, 12));
    if (pick < 97) return 8'($urandom_range(13, 40));
    if (pick < 99) return 8'($urandom_range(41, 254));
    return 8'd255;
  endfunction

  // Present one line byte and hold it until the transaction completes
  task automatic send_byte(input logic [7:0] value);
    int gap;
    int seen;
    gap = gap_cycles();
    if (gap > 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= value;
    seen = rx_taken;
    do @(negedge clk); while (rx_taken == seen);
  endtask

  task automatic release_rx();
    rx_valid <= 1'b0;
  endtask

  // Encode one decoded frame byte, escaping where required and now and then where not
  task automatic put_decoded(input logic [7:0] value);
    logic [7:0] coded;
    bit         must;
    bit         may;
    coded = value - 8'd1;
    must  = (value == SYNC_BYTE) || (value == MARK_BYTE);
    may   = (coded != SYNC_BYTE) && (coded != MARK_BYTE) && ($urandom_range(0, 7) == 0);
    if (must || may) begin
      send_byte(MARK_BYTE);
      if ($urandom_range(0, 9) == 0) send_byte(MARK_BYTE);
      send_byte(coded);
    end else begin
      send_byte(value);
    end
  endtask

  // Send a frame; corrupt the checksum if asked, stop before decoded byte cut if cut >= 0
  task automatic send_frame(input logic [7:0] node, input logic [7:0] len,
                            input bit corrupt, input int cut);
    int         total;
    logic [7:0] sum;
    logic [7:0] value;
    total = (len == 8'd0) ? 2 : int'(len) + 2;
    sum = 8'd0;
    send_byte(SYNC_BYTE);
    for (int i = 0; i < total; i++) begin
      if (i == cut) break;
      if (i == 0) value = node;
      else if (i == 1) value = len;
      else if (i == total - 1) value = corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum;
      else value = 8'($urandom_range(0, 255));
      put_decoded(value);
      sum = sum + value;
    end
  endtask

  task automatic write_host(input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_HOST_ADDRESS;
    pwdata  <= {{(DATA_W-8){1'b0}}, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    host_now = value;
  endtask

  // Hold the sender until every expected byte is out, then let the pipe settle
  task automatic drain_results();
    release_rx();
    do @(negedge clk); while (outstanding != 0);
    repeat (3) @(negedge clk);
  endtask

  initial begin
    logic [7:0] node;
    logic [7:0] len;
    int         items;
    int         start;
    int         frame_idx;
    int         pick;
    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    rx_valid    = 1'b0;
    rx_byte     = 8'h00;
    rx_steady   = 1'b0;
    host_now    = 8'h00;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: noise before any sync
    write_host(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(MARK_BYTE);
    // Empty frame ends on its length byte
    send_byte(SYNC_BYTE);
    send_byte(host_now);
    send_byte(8'h00);
    // Repeated mark stays pending; length becomes 1, too short
    send_byte(SYNC_BYTE);
    send_byte(host_now);
    send_byte(MARK_BYTE);
    send_byte(MARK_BYTE);
    send_byte(8'h00);
    send_byte(host_now + 8'd1);
    // Sync while an escape is pending restarts; then a frame for another node
    send_byte(SYNC_BYTE);
    send_byte(host_now);
    send_byte(MARK_BYTE);
    send_byte(SYNC_BYTE);
    send_byte(~host_now);
    send_byte(8'h02);
    send_byte(8'h7F);
    send_byte(~host_now + 8'h02 + 8'h7F);
    // Bad checksum
    send_byte(SYNC_BYTE);
    send_byte(host_now);
    send_byte(8'h02);
    send_byte(8'h55);
    send_byte((host_now + 8'h02 + 8'h55) ^ 8'h01);
    drain_results();

    // Random phases, each under its own host address
    for (int phase = 1; phase <= 4; phase++) begin
      case (phase)
        1: write_host(8'hFF);
        2: write_host(8'($urandom_range(0, 255)));
        3: write_host(SYNC_BYTE);
        default: write_host(MARK_BYTE);
      endcase
      start = rx_taken;
      items = 0;
      frame_idx = 0;
      while (items < PHASE_ITEMS) begin
        rx_steady = ($urandom_range(0, 4) == 0);
        node = ($urandom_range(0, 4) != 0) ? host_now : 8'($urandom_range(0, 255));
        len = (phase == 2 && frame_idx == 3) ? 8'd255 : pick_length();
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          send_frame(node, len, $urandom_range(0, 6) == 0, -1);
        end else if (pick < 88) begin
          // Broken frame: cut short, the next sync drops it
          send_frame(node, len, 1'b0, $urandom_range(0, (len == 8'd0) ? 1 : int'(len) + 1));
        end else if (pick < 94) begin
          // Escape left pending when the next sync arrives
          send_byte(SYNC_BYTE);
          put_decoded(node);
          send_byte(MARK_BYTE);
        end else begin
          // Line noise
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
        end
        items = rx_taken - start;
        frame_idx++;
      end
      drain_results();
    end

    release_rx();
    do @(negedge clk); while (outstanding != 0);
    repeat (4) @(negedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("jvs_frame_receiver_test: done, clean");
    end else begin
      $display("jvs_frame_receiver_test: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
design/jvsfr_pkg.sv
design/jvsfr_apb_regs.sv
design/jvs_frame_receiver.sv
tb/jvs_frame_receiver_checker.sv
tb/jvs_frame_receiver_test.sv
